// ===== rtl/bcg_pkg.sv =====
package bcg_pkg;

  // coordinate and color widths
  localparam int COORD_W = 12;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int SIZE_W  = 13;
  localparam int NUM_CH  = 3;

  // largest supported screen
  localparam logic [SIZE_W-1:0] MAX_COLUMNS = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] MAX_ROWS    = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] MIN_SIZE    = SIZE_W'(2);

  // datapath widths
  localparam int EDGE_W = CHAN_W + COORD_W;        // edge blend, 255*Hm
  localparam int SUM_W  = EDGE_W + COORD_W;        // full weighted sum
  localparam int DEN_W  = 2 * COORD_W + 1;         // 2*Wm*Hm
  localparam int NUM_W  = SUM_W + 1;               // 2*S + D
  localparam int DIV_STEPS = CHAN_W;               // one quotient bit per stage

  // front stages plus divider stages
  localparam int PIPE_LAT = 4 + DIV_STEPS;

  // register reset values
  localparam logic [COLOR_W-1:0] TL_RESET = 24'hFF0000;
  localparam logic [COLOR_W-1:0] TR_RESET = 24'h0000FF;
  localparam logic [COLOR_W-1:0] BL_RESET = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] BR_RESET = 24'h00FF00;
  localparam logic [SIZE_W-1:0]  COLS_RESET = SIZE_W'(640);
  localparam logic [SIZE_W-1:0]  ROWS_RESET = SIZE_W'(480);

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_TOP_LEFT     = 3'd0,
    REG_TOP_RIGHT    = 3'd1,
    REG_BOTTOM_LEFT  = 3'd2,
    REG_BOTTOM_RIGHT = 3'd3,
    REG_COLUMNS      = 3'd4,
    REG_ROWS         = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } coord_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              clamped;
  } pixel_t;

endpackage

// ===== rtl/bilinear_color_gradient.sv =====
// A word accepted with start passes through four multiply/add stages and then
// an 8-stage restoring array that divides by (Wm*Hm), one quotient bit per stage;
// done strobes the result word as it leaves the last divider stage. Throughput:
// one word per cycle; busy stays low, a new coordinate may enter every cycle.
// Reset (rst, synchronous): clears the pipeline valid bits and returns the
// corner colors and screen size to their defaults. The receiver cannot stall.
module bilinear_color_gradient (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  bcg_pkg::coord_t              coord,
  output logic                         done,
  output bcg_pkg::pixel_t              pixel,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcg_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CW = bcg_pkg::COORD_W;
  localparam int NC = bcg_pkg::NUM_CH;

  // configuration registers
  logic [bcg_pkg::COLOR_W-1:0] tl_color, tr_color, bl_color, br_color;
  logic [bcg_pkg::SIZE_W-1:0]  columns, rows;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tl_color <= bcg_pkg::TL_RESET;
      tr_color <= bcg_pkg::TR_RESET;
      bl_color <= bcg_pkg::BL_RESET;
      br_color <= bcg_pkg::BR_RESET;
      columns  <= bcg_pkg::COLS_RESET;
      rows     <= bcg_pkg::ROWS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (bcg_pkg::reg_idx_t'(paddr[4:2]))
        bcg_pkg::REG_TOP_LEFT:     tl_color <= pwdata[bcg_pkg::COLOR_W-1:0];
        bcg_pkg::REG_TOP_RIGHT:    tr_color <= pwdata[bcg_pkg::COLOR_W-1:0];
        bcg_pkg::REG_BOTTOM_LEFT:  bl_color <= pwdata[bcg_pkg::COLOR_W-1:0];
        bcg_pkg::REG_BOTTOM_RIGHT: br_color <= pwdata[bcg_pkg::COLOR_W-1:0];
        bcg_pkg::REG_COLUMNS:      columns  <= pwdata[bcg_pkg::SIZE_W-1:0];
        bcg_pkg::REG_ROWS:         rows     <= pwdata[bcg_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (bcg_pkg::reg_idx_t'(paddr[4:2]))
      bcg_pkg::REG_TOP_LEFT:     prdata = 32'(tl_color);
      bcg_pkg::REG_TOP_RIGHT:    prdata = 32'(tr_color);
      bcg_pkg::REG_BOTTOM_LEFT:  prdata = 32'(bl_color);
      bcg_pkg::REG_BOTTOM_RIGHT: prdata = 32'(br_color);
      bcg_pkg::REG_COLUMNS:      prdata = 32'(columns);
      bcg_pkg::REG_ROWS:         prdata = 32'(rows);
      default:                   prdata = 32'd0;
    endcase
  end

  // effective screen size minus one
  logic [bcg_pkg::SIZE_W-1:0] cols_sat, rows_sat, cols_m1, rows_m1;
  logic [CW-1:0]              wm, hm;

  always_comb begin
    cols_sat = columns;
    if (columns < bcg_pkg::MIN_SIZE)    cols_sat = bcg_pkg::MIN_SIZE;
    if (columns > bcg_pkg::MAX_COLUMNS) cols_sat = bcg_pkg::MAX_COLUMNS;
    rows_sat = rows;
    if (rows < bcg_pkg::MIN_SIZE)       rows_sat = bcg_pkg::MIN_SIZE;
    if (rows > bcg_pkg::MAX_ROWS)       rows_sat = bcg_pkg::MAX_ROWS;
    cols_m1 = cols_sat - bcg_pkg::SIZE_W'(1);
    rows_m1 = rows_sat - bcg_pkg::SIZE_W'(1);
    wm = cols_m1[CW-1:0];
    hm = rows_m1[CW-1:0];
  end

  function automatic logic [bcg_pkg::CHAN_W-1:0] chan(
      input logic [bcg_pkg::COLOR_W-1:0] color, input int idx);
    chan = color[bcg_pkg::COLOR_W-1 - bcg_pkg::CHAN_W*idx -: bcg_pkg::CHAN_W];
  endfunction

  // stage 1: saturate coordinate, form complementary weights
  logic          s1_valid, s1_flag;
  logic [CW-1:0] s1_x, s1_y, s1_wx0, s1_wy0, s1_wm, s1_hm;
  logic [CW-1:0] x_sat, y_sat;
  logic          x_over, y_over;

  always_comb begin
    x_over = coord.column > wm;
    y_over = coord.row > hm;
    x_sat  = x_over ? wm : coord.column;
    y_sat  = y_over ? hm : coord.row;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start && !busy;
    s1_x   <= x_sat;
    s1_y   <= y_sat;
    s1_wx0 <= wm - x_sat;
    s1_wy0 <= hm - y_sat;
    s1_wm  <= wm;
    s1_hm  <= hm;
    s1_flag <= x_over || y_over;
  end

  // stage 2: blend down the left and right edges, form the divisor
  logic                          s2_valid, s2_flag;
  logic [CW-1:0]                 s2_x, s2_wx0;
  logic [2*CW-1:0]               s2_d;
  logic [bcg_pkg::EDGE_W-1:0]    s2_left [NC];
  logic [bcg_pkg::EDGE_W-1:0]    s2_right [NC];

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_flag <= s1_flag;
    s2_x    <= s1_x;
    s2_wx0  <= s1_wx0;
    s2_d    <= (2*CW)'(s1_wm) * (2*CW)'(s1_hm);
    for (int c = 0; c < NC; c++) begin
      s2_left[c]  <= bcg_pkg::EDGE_W'(chan(tl_color, c)) * bcg_pkg::EDGE_W'(s1_wy0)
                   + bcg_pkg::EDGE_W'(chan(bl_color, c)) * bcg_pkg::EDGE_W'(s1_y);
      s2_right[c] <= bcg_pkg::EDGE_W'(chan(tr_color, c)) * bcg_pkg::EDGE_W'(s1_wy0)
                   + bcg_pkg::EDGE_W'(chan(br_color, c)) * bcg_pkg::EDGE_W'(s1_y);
    end
  end

  // stage 3: blend across the row
  logic                       s3_valid, s3_flag;
  logic [2*CW-1:0]            s3_d;
  logic [bcg_pkg::SUM_W-1:0]  s3_sum [NC];

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
    s3_flag <= s2_flag;
    s3_d    <= s2_d;
    for (int c = 0; c < NC; c++) begin
      s3_sum[c] <= bcg_pkg::SUM_W'(s2_left[c]) * bcg_pkg::SUM_W'(s2_wx0)
                 + bcg_pkg::SUM_W'(s2_right[c]) * bcg_pkg::SUM_W'(s2_x);
    end
  end

  // stage 4: rounding numerator 2*S + D and denominator 2*D
  logic                       s4_valid, s4_flag;
  logic [bcg_pkg::DEN_W-1:0]  s4_den;
  logic [bcg_pkg::NUM_W-1:0]  s4_num [NC];

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else     s4_valid <= s3_valid;
    s4_flag <= s3_flag;
    s4_den  <= {s3_d, 1'b0};
    for (int c = 0; c < NC; c++) begin
      s4_num[c] <= {s3_sum[c], 1'b0} + bcg_pkg::NUM_W'(s3_d);
    end
  end

  // divider: one restoring step per stage, MSB of the quotient first
  localparam int DS = bcg_pkg::DIV_STEPS;

  logic [DS-1:0]                 dv_valid;
  logic                          dv_flag [DS];
  logic [bcg_pkg::DEN_W-1:0]     dv_den  [DS];
  logic [bcg_pkg::NUM_W-1:0]     dv_rem  [DS][NC];
  logic [bcg_pkg::CHAN_W-1:0]    dv_quo  [DS][NC];

  logic                          st_flag [DS];
  logic [bcg_pkg::DEN_W-1:0]     st_den  [DS];
  logic [bcg_pkg::NUM_W-1:0]     st_rem  [DS][NC];
  logic [bcg_pkg::CHAN_W-1:0]    st_quo  [DS][NC];
  logic [bcg_pkg::NUM_W-1:0]     st_rem_next [DS][NC];
  logic [bcg_pkg::CHAN_W-1:0]    st_quo_next [DS][NC];
  logic [bcg_pkg::NUM_W:0]       st_diff [DS][NC];
  logic [bcg_pkg::NUM_W-1:0]     st_trial [DS];

  // stage inputs
  always_comb begin
    for (int k = 0; k < DS; k++) begin
      if (k == 0) begin
        st_flag[k] = s4_flag;
        st_den[k]  = s4_den;
        for (int c = 0; c < NC; c++) begin
          st_rem[k][c] = s4_num[c];
          st_quo[k][c] = '0;
        end
      end else begin
        st_flag[k] = dv_flag[k-1];
        st_den[k]  = dv_den[k-1];
        for (int c = 0; c < NC; c++) begin
          st_rem[k][c] = dv_rem[k-1][c];
          st_quo[k][c] = dv_quo[k-1][c];
        end
      end
    end
  end

  // trial subtract of the shifted denominator
  always_comb begin
    for (int k = 0; k < DS; k++) begin
      st_trial[k] = bcg_pkg::NUM_W'(st_den[k]) << (DS - 1 - k);
      for (int c = 0; c < NC; c++) begin
        st_diff[k][c] = {1'b0, st_rem[k][c]} - {1'b0, st_trial[k]};
        st_quo_next[k][c] = st_quo[k][c];
        if (!st_diff[k][c][bcg_pkg::NUM_W]) begin
          st_rem_next[k][c] = st_diff[k][c][bcg_pkg::NUM_W-1:0];
          st_quo_next[k][c][DS-1-k] = 1'b1;
        end else begin
          st_rem_next[k][c] = st_rem[k][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= '0;
    end else begin
      dv_valid <= {dv_valid[DS-2:0], s4_valid};
    end
    for (int k = 0; k < DS; k++) begin
      dv_flag[k] <= st_flag[k];
      dv_den[k]  <= st_den[k];
      for (int c = 0; c < NC; c++) begin
        dv_rem[k][c] <= st_rem_next[k][c];
        dv_quo[k][c] <= st_quo_next[k][c];
      end
    end
  end

  // result word
  assign done          = dv_valid[DS-1];
  assign pixel.red     = dv_quo[DS-1][0];
  assign pixel.green   = dv_quo[DS-1][1];
  assign pixel.blue    = dv_quo[DS-1][2];
  assign pixel.clamped = dv_flag[DS-1];

endmodule

// ===== rtl/bcg_checker.sv =====
module bcg_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LAT = bcg_pkg::PIPE_LAT;

  // every accepted word comes out after the fixed latency
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted word did not produce a result on time");

  // no result appears without a matching accept
  a_done_has_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without an accepted word");

  // full rate: the block never refuses a word
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("start refused");

endmodule

bind bilinear_color_gradient bcg_checker u_bcg_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== sim/bilinear_color_gradient_test.sv =====
module bilinear_color_gradient_test;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int WORD_TARGET = 1750;
  localparam int CALM_WORDS  = 250;

  // register slots past the end of the map; writes there must not land
  localparam logic [2:0] SPARE_SLOT_A = 3'd6;
  localparam logic [2:0] SPARE_SLOT_B = 3'd7;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  bcg_pkg::coord_t             coord;
  logic                        done;
  bcg_pkg::pixel_t             pixel;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bcg_pkg::ADDR_W-1:0]  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  bilinear_color_gradient DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .coord   (coord),
    .done    (done),
    .pixel   (pixel),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the screen setup
  logic [bcg_pkg::COLOR_W-1:0] shadow_top_left     = bcg_pkg::TL_RESET;
  logic [bcg_pkg::COLOR_W-1:0] shadow_top_right    = bcg_pkg::TR_RESET;
  logic [bcg_pkg::COLOR_W-1:0] shadow_bottom_left  = bcg_pkg::BL_RESET;
  logic [bcg_pkg::COLOR_W-1:0] shadow_bottom_right = bcg_pkg::BR_RESET;
  logic [bcg_pkg::SIZE_W-1:0]  shadow_columns      = bcg_pkg::COLS_RESET;
  logic [bcg_pkg::SIZE_W-1:0]  shadow_rows         = bcg_pkg::ROWS_RESET;

  bcg_pkg::pixel_t pending_pixels [$];
  int     coords_sent;
  int     pixels_compared;
  int     mismatch_count;
  int     settings_used;
  int     cycle_count;
  int     gap_pct;

  // corner and edge cases at the reset setup (640x480, red/blue/yellow/green)
  typedef struct packed {
    bcg_pkg::coord_t c;
    logic            known;
    bcg_pkg::pixel_t want;
  } corner_row_t;

  localparam int CORNER_ROWS = 18;
  corner_row_t corner_rows [CORNER_ROWS] = '{
    {12'd0,    12'd0,    1'b1, 8'hFF, 8'h00, 8'h00, 1'b0},
    {12'd639,  12'd0,    1'b1, 8'h00, 8'h00, 8'hFF, 1'b0},
    {12'd0,    12'd479,  1'b1, 8'hFF, 8'hFF, 8'h00, 1'b0},
    {12'd639,  12'd479,  1'b1, 8'h00, 8'hFF, 8'h00, 1'b0},
    {12'd640,  12'd0,    1'b1, 8'h00, 8'h00, 8'hFF, 1'b1},
    {12'd0,    12'd480,  1'b1, 8'hFF, 8'hFF, 8'h00, 1'b1},
    {12'd4095, 12'd4095, 1'b1, 8'h00, 8'hFF, 8'h00, 1'b1},
    {12'd4095, 12'd0,    1'b1, 8'h00, 8'h00, 8'hFF, 1'b1},
    {12'd0,    12'd4095, 1'b1, 8'hFF, 8'hFF, 8'h00, 1'b1},
    {12'd320,  12'd240,  1'b0, 25'd0},
    {12'd1,    12'd1,    1'b0, 25'd0},
    {12'd638,  12'd478,  1'b0, 25'd0},
    {12'd319,  12'd0,    1'b0, 25'd0},
    {12'd0,    12'd239,  1'b0, 25'd0},
    {12'hAAA,  12'h555,  1'b0, 25'd0},
    {12'h555,  12'h0AA,  1'b0, 25'd0},
    {12'd100,  12'd400,  1'b0, 25'd0},
    {12'd639,  12'd240,  1'b0, 25'd0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // screen size as the datapath uses it: at least 2, at most the maximum
  function automatic longint unsigned usable_size(logic [bcg_pkg::SIZE_W-1:0] v,
                                                  logic [bcg_pkg::SIZE_W-1:0] lim);
    longint unsigned s;
    s = v;
    if (s < bcg_pkg::MIN_SIZE) s = bcg_pkg::MIN_SIZE;
    if (s > lim) s = lim;
    return s;
  endfunction

  // bilinear blend of the four corners, rounded half up per channel
  function automatic bcg_pkg::pixel_t blend_pixel(bcg_pkg::coord_t c);
    longint unsigned wm, hm, x, y, d, s, q, shift;
    longint unsigned tl, tr, bl, br;
    logic [bcg_pkg::CHAN_W-1:0] chan [bcg_pkg::NUM_CH];
    logic off_screen;
    wm = usable_size(shadow_columns, bcg_pkg::MAX_COLUMNS) - 1;
    hm = usable_size(shadow_rows, bcg_pkg::MAX_ROWS) - 1;
    x = c.column;
    y = c.row;
    off_screen = 1'b0;
    if (x > wm) begin
      x = wm;
      off_screen = 1'b1;
    end
    if (y > hm) begin
      y = hm;
      off_screen = 1'b1;
    end
    d = wm * hm;
    for (int i = 0; i < bcg_pkg::NUM_CH; i++) begin
      shift = bcg_pkg::CHAN_W * (bcg_pkg::NUM_CH - 1 - i);
      tl = (shadow_top_left >> shift) & 8'hFF;
      tr = (shadow_top_right >> shift) & 8'hFF;
      bl = (shadow_bottom_left >> shift) & 8'hFF;
      br = (shadow_bottom_right >> shift) & 8'hFF;
      s = tl * (wm - x) * (hm - y) + tr * x * (hm - y)
        + bl * (wm - x) * y + br * x * y;
      q = (2 * s + d) / (2 * d);
      if (q > 255) q = 255;
      chan[i] = bcg_pkg::CHAN_W'(q);
    end
    return '{red: chan[0], green: chan[1], blue: chan[2], clamped: off_screen};
  endfunction

  // bus write: setup cycle, then access until pready
  task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      bcg_pkg::REG_TOP_LEFT:     shadow_top_left     = data[bcg_pkg::COLOR_W-1:0];
      bcg_pkg::REG_TOP_RIGHT:    shadow_top_right    = data[bcg_pkg::COLOR_W-1:0];
      bcg_pkg::REG_BOTTOM_LEFT:  shadow_bottom_left  = data[bcg_pkg::COLOR_W-1:0];
      bcg_pkg::REG_BOTTOM_RIGHT: shadow_bottom_right = data[bcg_pkg::COLOR_W-1:0];
      bcg_pkg::REG_COLUMNS:      shadow_columns      = data[bcg_pkg::SIZE_W-1:0];
      bcg_pkg::REG_ROWS:         shadow_rows         = data[bcg_pkg::SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] tl, input logic [31:0] tr,
                           input logic [31:0] bl, input logic [31:0] br,
                           input logic [31:0] cols, input logic [31:0] rows);
    write_reg(bcg_pkg::REG_TOP_LEFT, tl);
    write_reg(bcg_pkg::REG_TOP_RIGHT, tr);
    write_reg(bcg_pkg::REG_BOTTOM_LEFT, bl);
    write_reg(bcg_pkg::REG_BOTTOM_RIGHT, br);
    write_reg(bcg_pkg::REG_COLUMNS, cols);
    write_reg(bcg_pkg::REG_ROWS, rows);
    // spare slots last, so any aliasing shows up in the next pixels
    write_reg(SPARE_SLOT_A, $urandom);
    write_reg(SPARE_SLOT_B, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // present one coordinate word, with an occasional idle burst ahead of it
  task automatic send_coord(input bcg_pkg::coord_t c, input logic known,
                            input bcg_pkg::pixel_t want);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    coord <= c;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(known ? want : blend_pixel(c));
    coords_sent++;
  endtask

  // mostly on screen, some on the edges, some anywhere in the field
  function automatic logic [bcg_pkg::COORD_W-1:0] pick_coord(longint unsigned n);
    case ($urandom_range(0, 7))
      0: return bcg_pkg::COORD_W'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? bcg_pkg::COORD_W'(n - 1) : '0;
      2: return bcg_pkg::COORD_W'(n);
      default: return bcg_pkg::COORD_W'($urandom_range(0, int'(n - 1)));
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(2, 16);
      default: return $urandom_range(2, 4096);
    endcase
  endfunction

  task automatic run_random(input int count);
    bcg_pkg::coord_t c;
    longint unsigned w, h;
    w = usable_size(shadow_columns, bcg_pkg::MAX_COLUMNS);
    h = usable_size(shadow_rows, bcg_pkg::MAX_ROWS);
    repeat (count) begin
      c.column = pick_coord(w);
      c.row    = pick_coord(h);
      send_coord(c, 1'b0, '0);
    end
  endtask

  // stop issuing and let the pipeline empty before touching registers
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (bcg_pkg::PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: every strobed word is matched against the oldest prediction
  always @(posedge clk) begin : pixel_check
    bcg_pkg::pixel_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel expected none got %h", $time, pixel);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_compared++;
        check_field("red", want.red, pixel.red);
        check_field("green", want.green, pixel.green);
        check_field("blue", want.blue, pixel.blue);
        check_field("clamped", want.clamped, pixel.clamped);
      end
    end
  end

  initial begin : stimulus
    rst     <= 1'b1;
    start   <= 1'b0;
    coord   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    gap_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset setup first, so the register defaults get checked too
    gap_pct = 30;
    foreach (corner_rows[i])
      send_coord(corner_rows[i].c, corner_rows[i].known, corner_rows[i].want);
    wait_drained();

    // extreme setups: smallest and largest screens, flat and full colors
    configure(32'h000000, 32'hFFFFFF, 32'hFFFFFF, 32'h000000, 32'd2, 32'd2);
    run_random(60);
    wait_drained();
    gap_pct = 0;
    configure(32'hFFFFFF, 32'h000000, 32'h000000, 32'hFFFFFF, 32'd4096, 32'd4096);
    run_random(100);
    wait_drained();
    // sizes under the minimum, junk in the upper data bits
    gap_pct = 50;
    configure($urandom, $urandom, $urandom, $urandom, 32'hFFFF_E000, 32'h0000_0001);
    run_random(60);
    wait_drained();
    // sizes over the maximum, then the smallest width with the largest height and the reverse
    gap_pct = 20;
    configure($urandom, $urandom, $urandom, $urandom, 32'h0000_1FFF, 32'd4097);
    run_random(100);
    wait_drained();
    configure($urandom, $urandom, $urandom, $urandom, 32'd2, 32'd4096);
    run_random(60);
    wait_drained();
    configure($urandom, $urandom, $urandom, $urandom, 32'd4096, 32'd2);
    run_random(60);
    wait_drained();

    // random setups, each with its own amount of source idling
    while (coords_sent < WORD_TARGET - CALM_WORDS) begin
      gap_pct = 25 * $urandom_range(0, 2);
      configure($urandom, $urandom, $urandom, $urandom, pick_size(), pick_size());
      run_random($urandom_range(80, 200));
      wait_drained();
    end

    // back to back words to finish
    gap_pct = 0;
    configure($urandom, $urandom, $urandom, $urandom, pick_size(), pick_size());
    run_random(CALM_WORDS);
    wait_drained();

    $display("run: %0d coordinate words over %0d screen setups, %0d pixels compared",
             coords_sent, settings_used, pixels_compared);
    $display("run: %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== bilinear_color_gradient.f =====
rtl/bcg_pkg.sv
rtl/bilinear_color_gradient.sv
rtl/bcg_checker.sv
sim/bilinear_color_gradient_test.sv
